/* sv/vcc_pkg.sv */
package vcc_pkg;

   localparam int PIX_W          = 16;
   localparam int PROD_W         = 2 * PIX_W;
   localparam int PART_W         = PROD_W + 2;
   localparam int SUM_W          = PROD_W + 4;
   localparam int DIM_W          = 11;
   localparam int ROW_W          = 10;
   localparam int CSR_DATA_W     = 48;
   localparam int CSR_INDEX_W    = 3;
   localparam int TAPS           = 3;
   localparam int KERNEL_SIZE    = 3;
   localparam int MARGIN         = KERNEL_SIZE & ~1;
   localparam int BASE           = 2 - MARGIN;
   localparam int MIN_SIZE       = 3;
   localparam int MAX_HEIGHT     = 1024;
   localparam int MAX_WIDTH_DEF  = 1024;
   localparam int FIFO_DEPTH     = 8;

   localparam logic [DIM_W-1:0]      WIDTH_RESET  = DIM_W'(640);
   localparam logic [DIM_W-1:0]      HEIGHT_RESET = DIM_W'(480);
   localparam logic [CSR_DATA_W-1:0] KTOP_RESET   = '0;
   localparam logic [CSR_DATA_W-1:0] KMID_RESET   = CSR_DATA_W'(65536);
   localparam logic [CSR_DATA_W-1:0] KBOT_RESET   = '0;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_IMAGE_WIDTH  = 3'd0,
      CSR_IMAGE_HEIGHT = 3'd1,
      CSR_KERNEL_TOP   = 3'd2,
      CSR_KERNEL_MID   = 3'd3,
      CSR_KERNEL_BOT   = 3'd4
   } csr_index_type;

   typedef logic signed [PIX_W-1:0] sample_type;

endpackage

/* sv/valid_2d_convolution_clamped.sv */
// Channel  Direction  Ports                               Handshake
// req      in         req_pixel_in                        req_valid / req_ready
// rsp      out        rsp_pixel_out, rsp_frame_end        rsp_valid / rsp_ready
// csr      in         csr_index, csr_wdata                csr_wen, no wait
//
// One pixel per cycle while req_ready is high; results pass the window, product and
// partial-sum registers into the output queue. Both line stores share one memory
// word per column, read at accept, written back in the next cycle. After reset a
// clearing pass zeroes the memory with req_ready low. The 8-word queue is reserved
// at accept, so rsp stalls stop input once queued and in-flight results fill it.
module valid_2d_convolution_clamped
   import vcc_pkg::*;
#(
   parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic signed [PIX_W-1:0] req_pixel_in,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic signed [PIX_W-1:0] rsp_pixel_out,
   output logic                   rsp_frame_end,
   input  logic                   csr_wen,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int COL_W = $clog2(MAX_WIDTH);
   localparam int CMP_W = (COL_W + 2 > DIM_W + 1) ? COL_W + 2 : DIM_W + 1;
   localparam int PTR_W = $clog2(FIFO_DEPTH);
   localparam int CNT_W = $clog2(FIFO_DEPTH + 1);
   localparam int MEM_W = 2 * PIX_W;

   // configuration
   logic [DIM_W-1:0]      width_ff, height_ff;
   logic [CSR_DATA_W-1:0] kernel_ff [TAPS];

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff     <= WIDTH_RESET;
         height_ff    <= HEIGHT_RESET;
         kernel_ff[0] <= KTOP_RESET;
         kernel_ff[1] <= KMID_RESET;
         kernel_ff[2] <= KBOT_RESET;
      end else if (csr_wen) begin
         case (csr_index_type'(csr_index))
            CSR_IMAGE_WIDTH:  width_ff     <= csr_wdata[DIM_W-1:0];
            CSR_IMAGE_HEIGHT: height_ff    <= csr_wdata[DIM_W-1:0];
            CSR_KERNEL_TOP:   kernel_ff[0] <= csr_wdata;
            CSR_KERNEL_MID:   kernel_ff[1] <= csr_wdata;
            CSR_KERNEL_BOT:   kernel_ff[2] <= csr_wdata;
            default: ;
         endcase
      end
   end

   // position counters
   logic [COL_W-1:0] col_ff, col_in;
   logic [ROW_W-1:0] row_ff, row_in;
   logic [CMP_W-1:0] width_ext, width_sat;
   logic [DIM_W-1:0] height_sat;
   logic             row_end, frame_end, has_result, req_fire;
   logic             clear_ff;
   logic [CNT_W-1:0] pending_ff, pending_in;

   assign req_fire = req_valid && req_ready;
   assign req_ready = !clear_ff && (pending_ff < CNT_W'(FIFO_DEPTH));

   always_comb begin
      width_ext = CMP_W'(width_ff);
      if (width_ext < CMP_W'(MIN_SIZE))
         width_sat = CMP_W'(MIN_SIZE);
      else if (width_ext > CMP_W'(MAX_WIDTH))
         width_sat = CMP_W'(MAX_WIDTH);
      else
         width_sat = width_ext;
      if (height_ff < DIM_W'(MIN_SIZE))
         height_sat = DIM_W'(MIN_SIZE);
      else if (height_ff > DIM_W'(MAX_HEIGHT))
         height_sat = DIM_W'(MAX_HEIGHT);
      else
         height_sat = height_ff;
      row_end    = (CMP_W'(col_ff) + CMP_W'(1)) >= width_sat;
      frame_end  = row_end && ((DIM_W'(row_ff) + DIM_W'(1)) >= height_sat);
      has_result = (row_ff >= ROW_W'(MARGIN)) && (CMP_W'(col_ff) >= CMP_W'(MARGIN));
      col_in = col_ff;
      row_in = row_ff;
      if (req_fire) begin
         if (row_end) begin
            col_in = '0;
            row_in = frame_end ? '0 : row_ff + ROW_W'(1);
         end else begin
            col_in = col_ff + COL_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // line store memory: upper half is row -2, lower half row -1
   logic [MEM_W-1:0] line_mem [MAX_WIDTH];
   logic [MEM_W-1:0] rd_data_ff;
   logic [COL_W-1:0] clear_addr_ff;
   logic             mem_we;
   logic [COL_W-1:0] mem_waddr;
   logic [MEM_W-1:0] mem_wdata;

   logic             s1_valid_ff, s1_res_ff, s1_end_ff;
   logic [COL_W-1:0] s1_col_ff;
   sample_type       s1_pix_ff;
   sample_type       top, mid;

   assign top = rd_data_ff[MEM_W-1:PIX_W];
   assign mid = rd_data_ff[PIX_W-1:0];

   always_comb begin
      if (clear_ff) begin
         mem_we    = 1'b1;
         mem_waddr = clear_addr_ff;
         mem_wdata = '0;
      end else begin
         mem_we    = s1_valid_ff;
         mem_waddr = s1_col_ff;
         mem_wdata = {mid, s1_pix_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we)
         line_mem[mem_waddr] <= mem_wdata;
      if (req_fire)
         rd_data_ff <= line_mem[col_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_ff      <= 1'b1;
         clear_addr_ff <= '0;
      end else if (clear_ff) begin
         clear_addr_ff <= clear_addr_ff + COL_W'(1);
         if (clear_addr_ff == COL_W'(MAX_WIDTH - 1))
            clear_ff <= 1'b0;
      end
   end

   // stage 1: memory data back, shift window
   always_ff @(posedge clock) begin
      if (reset)
         s1_valid_ff <= 1'b0;
      else
         s1_valid_ff <= req_fire;
      if (req_fire) begin
         s1_pix_ff <= req_pixel_in;
         s1_col_ff <= col_ff;
         s1_res_ff <= has_result;
         s1_end_ff <= frame_end;
      end
   end

   sample_type win_ff [TAPS][TAPS];
   logic       s2_valid_ff, s2_res_ff, s2_end_ff;

   always_ff @(posedge clock) begin
      if (s1_valid_ff) begin
         for (int r = 0; r < TAPS; r++) begin
            win_ff[r][0] <= win_ff[r][1];
            win_ff[r][1] <= win_ff[r][2];
         end
         win_ff[0][2] <= top;
         win_ff[1][2] <= mid;
         win_ff[2][2] <= s1_pix_ff;
         s2_res_ff    <= s1_res_ff;
         s2_end_ff    <= s1_end_ff;
      end
   end

   // stage 2: products
   logic signed [PROD_W-1:0] prod_ff [TAPS*TAPS];
   logic                     s3_valid_ff, s3_res_ff, s3_end_ff;

   for (genvar r = 0; r < TAPS; r++) begin : g_row
      for (genvar c = 0; c < TAPS; c++) begin : g_col
         if (r < KERNEL_SIZE && c < KERNEL_SIZE) begin : g_tap
            sample_type coef;
            assign coef = kernel_ff[r][PIX_W*c +: PIX_W];
            always_ff @(posedge clock) begin
               if (s2_valid_ff)
                  prod_ff[r*TAPS+c] <= coef * win_ff[BASE+r][BASE+c];
            end
         end else begin : g_zero
            always_ff @(posedge clock) begin
               if (s2_valid_ff)
                  prod_ff[r*TAPS+c] <= '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s2_valid_ff) begin
         s3_res_ff <= s2_res_ff;
         s3_end_ff <= s2_end_ff;
      end
   end

   // stage 3: row partial sums
   logic signed [PART_W-1:0] part_ff [TAPS];
   logic                     s4_valid_ff, s4_res_ff, s4_end_ff;

   always_ff @(posedge clock) begin
      if (s3_valid_ff) begin
         for (int r = 0; r < TAPS; r++)
            part_ff[r] <= PART_W'(prod_ff[r*TAPS]) + PART_W'(prod_ff[r*TAPS+1])
                          + PART_W'(prod_ff[r*TAPS+2]);
         s4_res_ff <= s3_res_ff;
         s4_end_ff <= s3_end_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         s4_valid_ff <= s3_valid_ff;
      end
   end

   // stage 4: final sum, clamp, push into output queue
   logic signed [SUM_W-1:0] sum;
   sample_type              clamped;

   always_comb begin
      sum = SUM_W'(part_ff[0]) + SUM_W'(part_ff[1]) + SUM_W'(part_ff[2]);
      if (sum > SUM_W'(32767))
         clamped = 16'sh7FFF;
      else if (sum < -SUM_W'(32768))
         clamped = 16'sh8000;
      else
         clamped = sum[PIX_W-1:0];
   end

   logic [PIX_W:0]   fifo_ff [FIFO_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push, pop;

   assign push = s4_valid_ff && s4_res_ff;
   assign pop  = rsp_valid && rsp_ready;

   always_ff @(posedge clock) begin
      if (push)
         fifo_ff[wr_ptr_ff] <= {s4_end_ff, clamped};
   end

   always_comb begin
      count_in   = count_ff + CNT_W'(push) - CNT_W'(pop);
      pending_in = pending_ff + CNT_W'(req_fire && has_result) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff  <= '0;
         rd_ptr_ff  <= '0;
         count_ff   <= '0;
         pending_ff <= '0;
      end else begin
         if (push)
            wr_ptr_ff <= wr_ptr_ff + PTR_W'(1);
         if (pop)
            rd_ptr_ff <= rd_ptr_ff + PTR_W'(1);
         count_ff   <= count_in;
         pending_ff <= pending_in;
      end
   end

   assign rsp_valid     = count_ff != '0;
   assign rsp_pixel_out = fifo_ff[rd_ptr_ff][PIX_W-1:0];
   assign rsp_frame_end = fifo_ff[rd_ptr_ff][PIX_W];

   // checks
   a_no_rmw_overlap: assert property (@(posedge clock) disable iff (reset)
      (req_fire && s1_valid_ff) |-> (s1_col_ff != col_ff))
      else $error("line store read and writeback hit the same column");

   a_queue_reserved: assert property (@(posedge clock) disable iff (reset)
      count_ff <= pending_ff)
      else $error("output queue holds more words than were reserved");

   a_queue_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (count_ff < CNT_W'(FIFO_DEPTH)) || pop)
      else $error("output queue overflow");

   a_clear_blocks: assert property (@(posedge clock) disable iff (reset)
      clear_ff |-> !s1_valid_ff && !req_ready)
      else $error("pixel accepted during line store clearing");

endmodule

/* dv/tb_top.sv */
`timescale 1ns / 100ps

module tb_top
   import vcc_pkg::*;
();

   localparam int WARMUP_WORDS  = 200;
   localparam int RANDOM_WORDS  = 920;
   localparam int DRAIN_CYCLES  = 32;
   localparam int STALL_LIMIT   = 20000;
   localparam int REPORT_LIMIT  = 10;

   typedef enum int {ROW_PREDICT, ROW_NONE, ROW_RESULT} word_check_type;
   typedef enum int {RSP_OPEN, RSP_COIN, RSP_BURSTY} rsp_mode_type;

   typedef struct {
      sample_type pixel;
      logic       last;
   } result_word_type;

   typedef struct {
      sample_type     pixel;
      word_check_type check;
      sample_type     exp_pixel;
      logic           exp_end;
   } directed_row_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   sample_type             req_pixel_in = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   sample_type             rsp_pixel_out;
   logic                   rsp_frame_end;
   logic                   csr_wen = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   // check mode of the word on the req port, moves with the payload
   word_check_type         word_check = ROW_PREDICT;
   sample_type             word_exp_pixel = '0;
   logic                   word_exp_end = 1'b0;

   // convolution state mirrored from the block
   logic [DIM_W-1:0]       width_reg = 11'd640;
   logic [DIM_W-1:0]       height_reg = 11'd480;
   logic [CSR_DATA_W-1:0]  kernel_reg [3] = '{48'd0, 48'd65536, 48'd0};
   sample_type             line_old [MAX_WIDTH_DEF];
   sample_type             line_new [MAX_WIDTH_DEF];
   sample_type             win_q [3][3];
   int unsigned            col_pos = 0;
   int unsigned            row_pos = 0;

   result_word_type        pending_results [$];
   int unsigned            mismatches = 0;
   int unsigned            idle_cycles = 0;
   int unsigned            burst_left = 0;

   rsp_mode_type           rsp_mode = RSP_OPEN;
   int unsigned            rsp_mode_left = 0;
   int unsigned            rsp_stall_left = 0;

   directed_row_type directed_rows [31] = '{
      '{16'sh0000, ROW_PREDICT, 16'sh0000, 1'b0},
      '{16'sh0000, ROW_PREDICT, 16'sh0000, 1'b0},
      '{16'sh0000, ROW_PREDICT, 16'sh0000, 1'b0},
      '{16'sh0000, ROW_PREDICT, 16'sh0000, 1'b0},
      '{16'sh0000, ROW_PREDICT, 16'sh0000, 1'b0},
      '{16'sh0000, ROW_PREDICT, 16'sh0000, 1'b0},
      '{16'sh0000, ROW_PREDICT, 16'sh0000, 1'b0},
      '{16'sh7FFF, ROW_NONE,    16'sh0000, 1'b0},
      '{16'sh7FFF, ROW_NONE,    16'sh0000, 1'b0},
      '{16'sh7FFF, ROW_NONE,    16'sh0000, 1'b0},
      '{16'sh7FFF, ROW_NONE,    16'sh0000, 1'b0},
      '{16'sh7FFF, ROW_NONE,    16'sh0000, 1'b0},
      '{16'sh7FFF, ROW_NONE,    16'sh0000, 1'b0},
      '{16'sh7FFF, ROW_NONE,    16'sh0000, 1'b0},
      '{16'sh7FFF, ROW_NONE,    16'sh0000, 1'b0},
      '{16'sh7FFF, ROW_RESULT,  16'sh7FFF, 1'b1},
      '{16'sh8000, ROW_NONE,    16'sh0000, 1'b0},
      '{16'sh8000, ROW_NONE,    16'sh0000, 1'b0},
      '{16'sh8000, ROW_NONE,    16'sh0000, 1'b0},
      '{16'sh8000, ROW_NONE,    16'sh0000, 1'b0},
      '{16'sh8000, ROW_NONE,    16'sh0000, 1'b0},
      '{16'sh8000, ROW_NONE,    16'sh0000, 1'b0},
      '{16'sh8000, ROW_NONE,    16'sh0000, 1'b0},
      '{16'sh8000, ROW_NONE,    16'sh0000, 1'b0},
      '{16'sh8000, ROW_RESULT,  16'sh8000, 1'b1},
      '{16'sh0000, ROW_PREDICT, 16'sh0000, 1'b0},
      '{16'sh0001, ROW_PREDICT, 16'sh0000, 1'b0},
      '{16'shFFFF, ROW_PREDICT, 16'sh0000, 1'b0},
      '{16'sh5555, ROW_PREDICT, 16'sh0000, 1'b0},
      '{16'shAAAA, ROW_PREDICT, 16'sh0000, 1'b0},
      '{16'sh0064, ROW_PREDICT, 16'sh0000, 1'b0}
   };

   valid_2d_convolution_clamped u_top (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_pixel_in  (req_pixel_in),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_pixel_out (rsp_pixel_out),
      .rsp_frame_end (rsp_frame_end),
      .csr_wen       (csr_wen),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   function automatic int unsigned clamp_dim(input logic [DIM_W-1:0] v, input int unsigned hi);
      if (v < MIN_SIZE) return MIN_SIZE;
      if (v > hi) return hi;
      return v;
   endfunction

   function automatic bit correlate_pixel(input sample_type px, output sample_type y,
                                          output logic last);
      int unsigned w, h, slot;
      sample_type top, mid;
      logic signed [PIX_W-1:0] coef;
      longint acc;
      bit row_end, hit;
      w = clamp_dim(width_reg, MAX_WIDTH_DEF);
      h = clamp_dim(height_reg, MAX_HEIGHT);
      slot = col_pos % MAX_WIDTH_DEF;
      top = line_old[slot];
      mid = line_new[slot];
      row_end = (col_pos + 1 >= w);
      last = row_end && (row_pos + 1 >= h);
      line_old[slot] = mid;
      line_new[slot] = px;
      for (int r = 0; r < 3; r++) begin
         win_q[r][0] = win_q[r][1];
         win_q[r][1] = win_q[r][2];
      end
      win_q[0][2] = top;
      win_q[1][2] = mid;
      win_q[2][2] = px;
      y = '0;
      hit = 1'b0;
      if (row_pos >= MARGIN && col_pos >= MARGIN) begin
         acc = 0;
         for (int r = 0; r < KERNEL_SIZE; r++) begin
            for (int c = 0; c < KERNEL_SIZE; c++) begin
               coef = kernel_reg[r][16*c +: 16];
               acc += longint'(coef) * longint'(win_q[BASE+r][BASE+c]);
            end
         end
         if (acc > 32767) acc = 32767;
         if (acc < -32768) acc = -32768;
         y = acc[PIX_W-1:0];
         hit = 1'b1;
      end
      if (row_end) begin
         col_pos = 0;
         row_pos = last ? 0 : row_pos + 1;
      end else begin
         col_pos = col_pos + 1;
      end
      return hit;
   endfunction

   function automatic int unsigned pixels_left_in_frame();
      int unsigned w, h, n;
      w = clamp_dim(width_reg, MAX_WIDTH_DEF);
      h = clamp_dim(height_reg, MAX_HEIGHT);
      n = (col_pos + 1 >= w) ? 1 : w - col_pos;
      if (row_pos + 1 < h) n += (h - row_pos - 1) * w;
      return n;
   endfunction

   function automatic sample_type rand_pixel();
      case ($urandom_range(0, 7))
         0: return 16'sh7FFF;
         1: return 16'sh8000;
         2: return 16'($urandom_range(0, 16) - 8);
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [CSR_DATA_W-1:0] rand_kernel_row();
      logic [CSR_DATA_W-1:0] k;
      case ($urandom_range(0, 5))
         0: k = {3{16'h8000}};
         1: k = {3{16'h7FFF}};
         2, 3: begin
            for (int c = 0; c < 3; c++) k[16*c +: 16] = 16'($urandom_range(0, 8) - 4);
         end
         default: k = {16'($urandom), 32'($urandom)};
      endcase
      return k;
   endfunction

   function automatic logic [CSR_DATA_W-1:0] size_word(input int unsigned small_hi);
      logic [CSR_DATA_W-1:0] d;
      d = {16'($urandom), 32'($urandom)};
      case ($urandom_range(0, 9))
         0: d[DIM_W-1:0] = DIM_W'($urandom_range(0, MIN_SIZE - 1));
         1: d[DIM_W-1:0] = DIM_W'($urandom_range(MAX_HEIGHT, 2047));
         default: d[DIM_W-1:0] = DIM_W'($urandom_range(MIN_SIZE, small_hi));
      endcase
      return d;
   endfunction

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      csr_wen <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_wen <= 1'b0;
      @(posedge clock);
   endtask

   task automatic send_word(input sample_type p, input word_check_type chk,
                            input sample_type exp_pixel, input logic exp_end);
      int unsigned gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 48);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid <= 1'b1;
      req_pixel_in <= p;
      word_check <= chk;
      word_exp_pixel <= exp_pixel;
      word_exp_end <= exp_end;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   always @(posedge clock) begin : rsp_stall
      if (rsp_mode_left == 0) begin
         rsp_mode = rsp_mode_type'($urandom_range(0, 2));
         rsp_mode_left = $urandom_range(50, 400);
      end else begin
         rsp_mode_left--;
      end
      if (rsp_stall_left != 0) begin
         rsp_stall_left--;
         rsp_ready <= 1'b0;
      end else begin
         case (rsp_mode)
            RSP_OPEN: rsp_ready <= 1'b1;
            RSP_COIN: rsp_ready <= 1'($urandom_range(0, 1));
            default: begin
               rsp_ready <= 1'b1;
               if ($urandom_range(0, 15) == 0) rsp_stall_left = $urandom_range(8, 40);
            end
         endcase
      end
   end

   always @(posedge clock) begin : scoreboard
      sample_type      y;
      logic            last;
      bit              has_exp;
      result_word_type exp_word;
      if (!reset) begin
         if (csr_wen) begin
            case (csr_index)
               CSR_IMAGE_WIDTH:  width_reg = csr_wdata[DIM_W-1:0];
               CSR_IMAGE_HEIGHT: height_reg = csr_wdata[DIM_W-1:0];
               CSR_KERNEL_TOP:   kernel_reg[0] = csr_wdata;
               CSR_KERNEL_MID:   kernel_reg[1] = csr_wdata;
               CSR_KERNEL_BOT:   kernel_reg[2] = csr_wdata;
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            if (correlate_pixel(req_pixel_in, y, last) && word_check == ROW_PREDICT)
               pending_results.push_back('{y, last});
            if (word_check == ROW_RESULT)
               pending_results.push_back('{word_exp_pixel, word_exp_end});
         end
         if (rsp_valid && rsp_ready) begin
            exp_word = '{'0, 1'b0};
            has_exp = (pending_results.size() != 0);
            if (has_exp) exp_word = pending_results.pop_front();
            if (!has_exp || rsp_pixel_out !== exp_word.pixel ||
                rsp_frame_end !== exp_word.last) begin
               mismatches++;
               if (mismatches <= REPORT_LIMIT)
                  $display("%0t rsp word: got pixel %0d end %0b, expected pixel %0d end %0b%s",
                           $realtime, rsp_pixel_out, rsp_frame_end, exp_word.pixel,
                           exp_word.last, has_exp ? "" : " (nothing pending)");
            end
         end
      end
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   initial begin : stimulus
      int unsigned total, n, w, h;
      for (int i = 0; i < MAX_WIDTH_DEF; i++) begin
         line_old[i] = '0;
         line_new[i] = '0;
      end
      for (int r = 0; r < 3; r++)
         for (int c = 0; c < 3; c++) win_q[r][c] = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // run the reset configuration through part of the first row
      for (int i = 0; i < WARMUP_WORDS; i++) send_word(rand_pixel(), ROW_PREDICT, '0, 1'b0);
      drain();

      write_csr(CSR_IMAGE_WIDTH, 48'd3);
      write_csr(CSR_IMAGE_HEIGHT, 48'd3);
      write_csr(CSR_KERNEL_TOP, {3{16'h0001}});
      write_csr(CSR_KERNEL_MID, {3{16'h0001}});
      write_csr(CSR_KERNEL_BOT, {3{16'h0001}});
      foreach (directed_rows[i])
         send_word(directed_rows[i].pixel, directed_rows[i].check,
                   directed_rows[i].exp_pixel, directed_rows[i].exp_end);
      drain();

      total = 0;
      while (total < RANDOM_WORDS) begin
         if ($urandom_range(0, 1)) write_csr(CSR_IMAGE_WIDTH, size_word(40));
         if ($urandom_range(0, 1)) write_csr(CSR_IMAGE_HEIGHT, size_word(8));
         for (int k = 0; k < 3; k++)
            if ($urandom_range(0, 1))
               write_csr(CSR_INDEX_W'(CSR_KERNEL_TOP + k), rand_kernel_row());
         if ($urandom_range(0, 4) == 0)
            write_csr(CSR_INDEX_W'(CSR_KERNEL_BOT + $urandom_range(1, 3)),
                      {16'($urandom), 32'($urandom)});
         w = clamp_dim(width_reg, MAX_WIDTH_DEF);
         h = clamp_dim(height_reg, MAX_HEIGHT);
         if (w * h > 400 || $urandom_range(0, 3) == 0) n = $urandom_range(1, 150);
         else n = pixels_left_in_frame() + $urandom_range(0, 2) * w * h;
         if (n > RANDOM_WORDS - total) n = RANDOM_WORDS - total;
         for (int i = 0; i < n; i++) send_word(rand_pixel(), ROW_PREDICT, '0, 1'b0);
         total += n;
         drain();
      end

      if (mismatches == 0 && pending_results.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

/* files.f */
sv/vcc_pkg.sv
sv/valid_2d_convolution_clamped.sv
dv/tb_top.sv
